### design/bfe_pkg.sv
package bfe_pkg;

   localparam int WIN_PREV   = 22;
   localparam int UUID_BYTES = 16;
   localparam int SEEN_W     = 5;

   localparam logic [SEEN_W-1:0] SEEN_MAX   = SEEN_W'(23);
   localparam logic [SEEN_W-1:0] SEEN_CHECK = SEEN_W'(WIN_PREV);

   localparam logic [7:0] PREFIX_HI = 8'h02;
   localparam logic [7:0] PREFIX_LO = 8'h15;

   localparam logic [7:0]        TEMP_FLOOR_BYTE = 8'd65;
   localparam logic signed [9:0] TEMP_OFFSET     = 10'sd110;
   localparam logic signed [9:0] TEMP_MIN        = -10'sd40;
   localparam logic signed [9:0] TEMP_MAX        = 10'sd125;

   localparam logic [63:0] UUID_UPPER_RESET     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] UUID_LOWER_RESET     = 64'hFFFF_FFFF_FFFF_FFE0;
   localparam logic [7:0]  PRESSURE_LIMIT_RESET = 8'd217;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UUID_UPPER     = 2'd0,
      CSR_UUID_LOWER     = 2'd1,
      CSR_PRESSURE_LIMIT = 2'd2
   } csr_index_type;

   typedef logic [WIN_PREV-1:0][7:0] window_type;

   typedef struct packed {
      logic [63:0] uuid_upper;
      logic [63:0] uuid_lower;
      logic [7:0]  pressure_limit;
   } cfg_type;

   typedef struct packed {
      logic               hit;
      logic [15:0]        major;
      logic [15:0]        minor;
      logic signed [7:0]  temperature;
   } match_type;

endpackage

### design/bfe_req_if.sv
interface bfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/bfe_rsp_if.sv
interface bfe_rsp_if;
   logic              valid;
   logic              ready;
   logic              beacon_found;
   logic [7:0]        pressure_psi;
   logic signed [7:0] temperature_c;
   logic [15:0]       id_major;
   logic [15:0]       id_minor;

   modport source (output valid, output beacon_found, output pressure_psi,
                   output temperature_c, output id_major, output id_minor, input ready);
   modport sink   (input valid, input beacon_found, input pressure_psi,
                   input temperature_c, input id_major, input id_minor, output ready);
endinterface

### design/bfe_csr_if.sv
interface bfe_csr_if;
   import bfe_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [63:0]            wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### design/beacon_frame_field_extractor.sv
// Channel  Direction  Payload                                               Note
// req_if   in         data_byte[7:0], last_byte                             one frame byte
// rsp_if   out        beacon_found, pressure_psi, temperature_c, majr/minr  one per frame
// csr_if   in         index[1:0], wdata[63:0]                               always ready
//
// One byte per cycle unless a held last byte blocks req_if. A byte is matched against
// the 22 previous bytes while it sits in the input register; a last byte loads the result register.
// Synchronous reset clears control and count and loads the configuration defaults.
// A stalled rsp_if holds a last byte in the input register until the result register
// frees, which blocks req_if; other bytes still flow.
module beacon_frame_field_extractor (
   input logic        clock,
   input logic        reset,
   bfe_req_if.sink    req_if,
   bfe_rsp_if.source  rsp_if,
   bfe_csr_if.sink    csr_if
);
   import bfe_pkg::*;

   cfg_type           cfg_ff;

   logic              in_valid_ff;
   logic [7:0]        in_data_ff;
   logic              in_last_ff;

   window_type        window_ff;
   window_type        window_in;
   logic [SEEN_W-1:0] bytes_seen_ff;
   logic              hit_ff;
   logic [15:0]       held_major_ff;
   logic [15:0]       held_minor_ff;
   logic signed [7:0] held_temp_ff;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [7:0]        rsp_pressure_ff;
   logic signed [7:0] rsp_temp_ff;
   logic [15:0]       rsp_major_ff;
   logic [15:0]       rsp_minor_ff;

   match_type         match;
   logic              out_free;
   logic              proc_en;
   logic              check_en;
   logic              new_hit;
   logic              hit_in;
   logic [15:0]       major_in;
   logic [15:0]       minor_in;
   logic signed [7:0] temp_in;

   bfe_match u_match (
      .window   (window_ff),
      .cur_byte (in_data_ff),
      .cfg      (cfg_ff),
      .match    (match)
   );

   // csr
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.uuid_upper     <= UUID_UPPER_RESET;
         cfg_ff.uuid_lower     <= UUID_LOWER_RESET;
         cfg_ff.pressure_limit <= PRESSURE_LIMIT_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_UUID_UPPER:     cfg_ff.uuid_upper     <= csr_if.wdata;
            CSR_UUID_LOWER:     cfg_ff.uuid_lower     <= csr_if.wdata;
            CSR_PRESSURE_LIMIT: cfg_ff.pressure_limit <= csr_if.wdata[7:0];
            default: ;
         endcase
      end
   end

   // flow control
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign proc_en      = in_valid_ff && (!in_last_ff || out_free);
   assign req_if.ready = !in_valid_ff || proc_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_data_ff <= req_if.data_byte;
         in_last_ff <= req_if.last_byte;
      end
   end

   // frame state
   assign check_en  = (bytes_seen_ff >= SEEN_CHECK) && !hit_ff;
   assign new_hit   = check_en && match.hit;
   assign hit_in    = hit_ff || new_hit;
   assign major_in  = new_hit ? match.major       : held_major_ff;
   assign minor_in  = new_hit ? match.minor       : held_minor_ff;
   assign temp_in   = new_hit ? match.temperature : held_temp_ff;
   assign window_in = {in_data_ff, window_ff[WIN_PREV-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         hit_ff        <= 1'b0;
      end else if (proc_en) begin
         if (in_last_ff) begin
            bytes_seen_ff <= '0;
            hit_ff        <= 1'b0;
         end else begin
            if (bytes_seen_ff < SEEN_MAX) begin
               bytes_seen_ff <= bytes_seen_ff + SEEN_W'(1);
            end
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc_en) begin
         window_ff     <= window_in;
         held_major_ff <= major_in;
         held_minor_ff <= minor_in;
         held_temp_ff  <= temp_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_en && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_en && in_last_ff) begin
         rsp_found_ff    <= hit_in;
         rsp_pressure_ff <= hit_in ? minor_in[7:0] : 8'd0;
         rsp_temp_ff     <= hit_in ? temp_in       : 8'sd0;
         rsp_major_ff    <= hit_in ? major_in      : 16'd0;
         rsp_minor_ff    <= hit_in ? minor_in      : 16'd0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.beacon_found  = rsp_found_ff;
   assign rsp_if.pressure_psi  = rsp_pressure_ff;
   assign rsp_if.temperature_c = rsp_temp_ff;
   assign rsp_if.id_major      = rsp_major_ff;
   assign rsp_if.id_minor      = rsp_minor_ff;

   // checks
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(proc_en && in_last_ff))
      else $error("response raised without a last byte");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= SEEN_MAX)
      else $error("byte count past saturation");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (proc_en && in_last_ff) |=> (bytes_seen_ff == '0) && !hit_ff)
      else $error("frame state not cleared after last byte");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_pressure_ff == 8'd0) &&
         (rsp_temp_ff == 8'sd0) && (rsp_major_ff == 16'd0) && (rsp_minor_ff == 16'd0))
      else $error("miss response carries nonzero fields");

endmodule

### design/bfe_match.sv
module bfe_match (
   input  bfe_pkg::window_type window,
   input  logic [7:0]          cur_byte,
   input  bfe_pkg::cfg_type    cfg,
   output bfe_pkg::match_type  match
);
   import bfe_pkg::*;

   logic [UUID_BYTES*8-1:0] uuid_all;
   logic [UUID_BYTES-1:0]   uuid_eq;
   logic                    prefix_ok;
   logic                    pressure_ok;
   logic                    temp_ok;
   logic signed [9:0]       temp_wide;
   logic                    temp_above;

   assign uuid_all = {cfg.uuid_upper, cfg.uuid_lower};

   always_comb begin
      for (int k = 0; k < UUID_BYTES; k++) begin
         uuid_eq[k] = (window[2 + k] == uuid_all[(UUID_BYTES-1-k)*8 +: 8]);
      end
   end

   assign prefix_ok   = (window[0] == PREFIX_HI) && (window[1] == PREFIX_LO);
   assign pressure_ok = (window[21] <= cfg.pressure_limit);

   assign temp_above = (cur_byte > TEMP_FLOOR_BYTE);
   assign temp_wide  = $signed({2'b00, cur_byte}) - TEMP_OFFSET;
   assign temp_ok    = !temp_above || ((temp_wide >= TEMP_MIN) && (temp_wide <= TEMP_MAX));

   assign match.hit         = prefix_ok && (&uuid_eq) && pressure_ok && temp_ok;
   assign match.major       = {window[18], window[19]};
   assign match.minor       = {window[20], window[21]};
   assign match.temperature = temp_above ? temp_wide[7:0] : 8'sd0;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bfe_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic              beacon_found;
      logic [7:0]        pressure_psi;
      logic signed [7:0] temperature_c;
      logic [15:0]       id_major;
      logic [15:0]       id_minor;
   } beacon_report_type;

   class frame_report_predictor;
      logic [63:0]       uuid_upper;
      logic [63:0]       uuid_lower;
      logic [7:0]        pressure_limit;
      logic [7:0]        win [WIN_PREV];
      int unsigned       seen;
      bit                hit;
      logic [15:0]       major;
      logic [15:0]       minor;
      logic signed [7:0] temperature;
      beacon_report_type expected_reports [$];
      int unsigned       mismatches;
      int unsigned       reports;
      int unsigned       beacons;

      function new();
         uuid_upper     = UUID_UPPER_RESET;
         uuid_lower     = UUID_LOWER_RESET;
         pressure_limit = PRESSURE_LIMIT_RESET;
         mismatches     = 0;
         reports        = 0;
         beacons        = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         foreach (win[i]) win[i] = 8'h00;
         seen        = 0;
         hit         = 0;
         major       = 16'h0000;
         minor       = 16'h0000;
         temperature = 8'sd0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [63:0] d);
         case (idx)
            CSR_UUID_UPPER:     uuid_upper = d;
            CSR_UUID_LOWER:     uuid_lower = d;
            CSR_PRESSURE_LIMIT: pressure_limit = d[7:0];
            default: ;
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         bit         ok;
         logic [7:0] ub;
         int         t;
         if (seen >= WIN_PREV && !hit) begin
            ok = (win[0] == PREFIX_HI) && (win[1] == PREFIX_LO);
            for (int k = 0; k < UUID_BYTES; k++) begin
               if (k < 8) ub = uuid_upper[63 - 8*k -: 8];
               else ub = uuid_lower[127 - 8*k -: 8];
               if (win[2+k] != ub) ok = 0;
            end
            t = (b > TEMP_FLOOR_BYTE) ? int'(b) - int'(TEMP_OFFSET) : 0;
            if (win[21] > pressure_limit) ok = 0;
            if (t < int'(TEMP_MIN) || t > int'(TEMP_MAX)) ok = 0;
            if (ok) begin
               hit         = 1;
               major       = {win[18], win[19]};
               minor       = {win[20], win[21]};
               temperature = 8'(t);
            end
         end
         for (int i = 0; i < WIN_PREV - 1; i++) win[i] = win[i+1];
         win[WIN_PREV-1] = b;
         if (seen < SEEN_MAX) seen++;
         if (last) begin
            expected_reports.push_back(beacon_report_type'{hit, minor[7:0], temperature,
                                                           major, minor});
            clear_frame();
         end
      endfunction

      function void compare_field(string name, logic [15:0] e, logic [15:0] a);
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report %0d: %s expected 'h%0h, got 'h%0h", reports, name, e, a);
         end
      endfunction

      function void check_report(beacon_report_type got);
         beacon_report_type exp;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report with no frame pending: %p", got);
            return;
         end
         exp = expected_reports.pop_front();
         compare_field("beacon_found", 16'(exp.beacon_found), 16'(got.beacon_found));
         compare_field("pressure_psi", 16'(exp.pressure_psi), 16'(got.pressure_psi));
         compare_field("temperature_c", 16'(exp.temperature_c), 16'(got.temperature_c));
         compare_field("id_major", exp.id_major, got.id_major);
         compare_field("id_minor", exp.id_minor, got.id_minor);
         reports++;
         if (got.beacon_found === 1'b1) beacons++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bfe_req_if req_if ();
   bfe_rsp_if rsp_if ();
   bfe_csr_if csr_if ();

   beacon_frame_field_extractor dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   frame_report_predictor predictor = new();

   logic [7:0]  frame [$];
   logic [63:0] cur_upper = UUID_UPPER_RESET;
   logic [63:0] cur_lower = UUID_LOWER_RESET;
   logic [7:0]  cur_limit = PRESSURE_LIMIT_RESET;
   int unsigned stall_pct = 15;
   int unsigned cycle_count = 0;
   int unsigned frames_sent = 0;
   int unsigned bytes_sent = 0;
   int unsigned csr_writes = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("beacon_frame_field_extractor regression: fail");
         $finish;
      end
   end

   always @(negedge clock) rsp_if.ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            predictor.note_byte(req_if.data_byte, req_if.last_byte);
         if (rsp_if.valid && rsp_if.ready)
            predictor.check_report(beacon_report_type'{rsp_if.beacon_found,
                                                       rsp_if.pressure_psi,
                                                       rsp_if.temperature_c, rsp_if.id_major,
                                                       rsp_if.id_minor});
         if (csr_if.valid && csr_if.ready)
            predictor.write_register(csr_if.index, csr_if.wdata);
      end
   end

   function automatic logic [7:0] pick_temp_byte();
      logic [7:0] edges [9] = '{8'd0, 8'd65, 8'd66, 8'd69, 8'd70, 8'd71,
                                8'd235, 8'd236, 8'd255};
      if ($urandom_range(3) == 0) return edges[$urandom_range(8)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_pressure();
      if ($urandom_range(1) == 0) return cur_limit + 8'($urandom_range(2)) - 8'd1;
      return 8'($urandom_range(255));
   endfunction

   function automatic void append_beacon(logic [15:0] maj, logic [15:0] mnr,
                                         logic [7:0] tbyte);
      frame.push_back(PREFIX_HI);
      frame.push_back(PREFIX_LO);
      for (int k = 0; k < 8; k++) frame.push_back(cur_upper[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++) frame.push_back(cur_lower[63 - 8*k -: 8]);
      frame.push_back(maj[15:8]);
      frame.push_back(maj[7:0]);
      frame.push_back(mnr[15:8]);
      frame.push_back(mnr[7:0]);
      frame.push_back(tbyte);
   endfunction

   function automatic void append_noise(int unsigned n);
      repeat (n) frame.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void make_frame();
      int unsigned kind;
      int unsigned pos;
      int unsigned keep;
      frame.delete();
      kind = $urandom_range(9);
      if (kind <= 5) begin
         append_noise($urandom_range(4));
         append_beacon(16'($urandom), {8'($urandom), pick_pressure()}, pick_temp_byte());
         if ($urandom_range(3) == 0) begin
            pos = frame.size() - 23 + $urandom_range(21);
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
         end
         if ($urandom_range(2) == 0)
            append_beacon(16'($urandom), {8'($urandom), pick_pressure()},
                          pick_temp_byte());
         append_noise($urandom_range(3));
      end else if (kind <= 7) begin
         append_beacon(16'($urandom), {8'($urandom), pick_pressure()}, pick_temp_byte());
         keep = $urandom_range(1, 22);
         while (frame.size() > keep) void'(frame.pop_back());
      end else begin
         append_noise($urandom_range(1, 40));
      end
   endfunction

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         while ($urandom_range(99) < stall_pct) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
         req_if.valid     = 1'b1;
         req_if.data_byte = frame[i];
         req_if.last_byte = (i == frame.size() - 1);
         do @(posedge clock); while (!req_if.ready);
         @(negedge clock);
      end
      frames_sent++;
      bytes_sent += frame.size();
   endtask

   task automatic wait_drain();
      req_if.valid = 1'b0;
      while (predictor.expected_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [63:0] d);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.wdata = d;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
      csr_writes++;
   endtask

   task automatic set_config(logic [63:0] upper, logic [63:0] lower, logic [7:0] limit);
      csr_write(CSR_UUID_UPPER, upper);
      csr_write(CSR_UUID_LOWER, lower);
      csr_write(CSR_PRESSURE_LIMIT, {$urandom, 24'($urandom), limit});
      cur_upper = upper;
      cur_lower = lower;
      cur_limit = limit;
   endtask

   task automatic run_phase(int unsigned budget);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         make_frame();
         send_frame();
      end
      wait_drain();
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_UUID_UPPER;
      csr_if.wdata     = 64'h0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // out-of-range index must leave the reset configuration alone
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      frame.delete();
      frame.push_back(8'hFF);
      send_frame();
      frame.delete();
      append_beacon(16'hFFFF, {8'h00, PRESSURE_LIMIT_RESET}, 8'd235);
      send_frame();
      wait_drain();

      set_config({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
      run_phase(400);
      set_config(64'h0, 64'h0, 8'h00);
      run_phase(300);
      stall_pct = 0;
      set_config({64{1'b1}}, {64{1'b1}}, 8'hFF);
      run_phase(400);
      stall_pct = 15;
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      set_config({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
      run_phase(500);
      set_config({$urandom, $urandom}, UUID_LOWER_RESET, 8'd128);
      run_phase(400);

      $display("covered %0d frames, %0d bytes, %0d reports with %0d beacons found",
               frames_sent, bytes_sent, predictor.reports, predictor.beacons);
      $display("%0d register writes over six settings, %0d mismatches",
               csr_writes, predictor.mismatches);
      if (predictor.mismatches == 0 && predictor.expected_reports.size() == 0) begin
         $display("beacon_frame_field_extractor regression: pass");
      end else begin
         $display("beacon_frame_field_extractor regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
design/bfe_pkg.sv
design/bfe_req_if.sv
design/bfe_rsp_if.sv
design/bfe_csr_if.sv
design/bfe_match.sv
design/beacon_frame_field_extractor.sv
test/tb_top.sv
